[hw/rtl/multi_producer_merge_queue_unit_defines.svh]
// Assertion macros shared by the merge queue RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef MULTI_PRODUCER_MERGE_QUEUE_UNIT_DEFINES_SVH
`define MULTI_PRODUCER_MERGE_QUEUE_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define MPMQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define MPMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mpmq_pkg.sv]
// Shared types and constants for the merge queue.
// Used by mpmq_front, mpmq_back and the top level; depends on nothing.
package mpmq_pkg;

   localparam int MaxProducers  = 8;
   localparam int ProducerDepth = 16;
   localparam int DataWidth     = 64;
   localparam int CfgWidth      = 5;
   localparam int CfgIdxWidth   = 1;

   localparam logic [1:0] OpPush    = 2'd0;
   localparam logic [1:0] OpInspect = 2'd1;
   localparam logic [1:0] OpRead    = 2'd2;
   localparam logic [1:0] OpRelease = 2'd3;

   localparam logic [CfgIdxWidth-1:0] RegProducerCount    = 1'd0;
   localparam logic [CfgIdxWidth-1:0] RegItemsPerProducer = 1'd1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  producer;
      logic [63:0] item;
      logic [7:0]  position;
      logic [7:0]  end_limit;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  begin_pos;
      logic [7:0]  end_pos;
      logic [63:0] read_item;
      logic [7:0]  next_position;
      logic        more_pending;
      logic        overflow;
   } rsp_type;

endpackage

[hw/rtl/mpmq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module mpmq_ram #(
   parameter int Width = 64,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/mpmq_front.sv]
// Front end: accepts commands and queues them for the back end.
// Depends on mpmq_pkg.
module mpmq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mpmq_pkg::req_type req_in,
   input  logic             flush,
   output logic             cmd_valid,
   output mpmq_pkg::req_type cmd,
   input  logic             cmd_take
);
   // Two-entry queue.
   mpmq_pkg::req_type q_ff [2];
   mpmq_pkg::req_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[0];

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (cmd_take) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = req_in;
         cnt_in = cnt_in + 2'd1;
      end
      if (flush) begin
         cnt_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end
endmodule

[hw/rtl/mpmq_back.sv]
// Back end: executes queued commands against producer and consumer rings.
// Depends on mpmq_pkg, mpmq_ram and the assertion macro header.
`include "multi_producer_merge_queue_unit_defines.svh"
module mpmq_back #(
   parameter int MaxProducers  = mpmq_pkg::MaxProducers,
   parameter int ProducerDepth = mpmq_pkg::ProducerDepth,
   parameter int DataWidth     = mpmq_pkg::DataWidth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cfg_clear,
   input  logic [3:0]        ring_count,
   input  logic [4:0]        items_per_producer,
   input  logic              cmd_valid,
   input  mpmq_pkg::req_type cmd,
   output logic              cmd_take,
   output logic              rsp_strobe,
   output mpmq_pkg::rsp_type rsp
);
   localparam int RingSlots = ProducerDepth + 1;
   localparam int ConsSlots = MaxProducers * ProducerDepth + 1;
   localparam int PW  = $clog2(MaxProducers) > 0 ? $clog2(MaxProducers) : 1;
   localparam int RW  = $clog2(RingSlots);
   localparam int PA  = $clog2(MaxProducers * RingSlots);
   localparam int CA  = $clog2(ConsSlots);
   localparam int NPW = $clog2(MaxProducers + 1);
   localparam int CSW = $clog2(ConsSlots + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_MOVE  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [RW-1:0] wpos_ff [MaxProducers];
   logic [RW-1:0] rpos_ff [MaxProducers];
   logic [RW-1:0] wpos_in [MaxProducers];
   logic [RW-1:0] rpos_in [MaxProducers];
   logic [7:0]    cw_ff, cw_in, cr_ff, cr_in;
   logic [MaxProducers-1:0] pend_ff, pend_in;
   logic [PW-1:0] di_ff, di_in;
   logic          ovf_ff, ovf_in;
   logic [CA-1:0] mv_addr_ff, mv_addr_in;
   mpmq_pkg::req_type cur_ff, cur_in;
   logic          strobe_ff, strobe_in;
   mpmq_pkg::rsp_type rsp_ff, rsp_in;

   logic [NPW-1:0] np;
   logic [4:0]     ni;
   logic [RW-1:0]  rs_last;
   logic [CSW-1:0] cs;
   logic [DataWidth-1:0] pdata, cdata;
   logic           p_we, c_we;
   logic [PA-1:0]  p_waddr, p_raddr;
   logic [CA-1:0]  c_raddr;
   logic [7:0]     ncw, pos_next;
   logic [5:0]     prod_idx;
   logic [PW-1:0]  pi;
   logic [RW-1:0]  nw;
   logic           take;

   always_comb begin
      if (ring_count == 4'd0) np = NPW'(1);
      else if (32'(ring_count) > MaxProducers) np = NPW'(MaxProducers);
      else np = NPW'(ring_count);
      if (items_per_producer == 5'd0) ni = 5'd1;
      else if (32'(items_per_producer) > ProducerDepth) ni = 5'(ProducerDepth);
      else ni = items_per_producer;
   end
   assign rs_last = RW'(ni);
   always_ff @(posedge clock) begin
      cs <= CSW'(32'(np) * 32'(ni) + 1);
   end

   assign prod_idx = cur_ff.producer;
   assign pi = PW'(prod_idx);
   assign nw = (wpos_ff[pi] == rs_last) ? '0 : wpos_ff[pi] + RW'(1);
   assign ncw = (9'(cw_ff) + 9'd1 >= 9'(cs)) ? 8'd0 : cw_ff + 8'd1;
   assign pos_next = (9'(cur_ff.position) + 9'd1 >= 9'(cs)) ? 8'd0
                                                           : cur_ff.position + 8'd1;

   assign p_waddr = PA'(32'(pi) * RingSlots + 32'(wpos_ff[pi]));
   assign p_raddr = PA'(32'(di_ff) * RingSlots + 32'(rpos_ff[di_ff]));
   assign c_raddr = CA'(cur_ff.position);

   mpmq_ram #(.Width(DataWidth), .Depth(MaxProducers * RingSlots)) u_pram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_waddr),
      .wr_data(cur_ff.item[DataWidth-1:0]), .rd_addr(p_raddr), .rd_data(pdata));
   mpmq_ram #(.Width(DataWidth), .Depth(ConsSlots)) u_cram (
      .clock(clock), .wr_en(c_we), .wr_addr(mv_addr_ff),
      .wr_data(pdata), .rd_addr(c_raddr), .rd_data(cdata));

   assign take = (state_ff == ST_IDLE) && cmd_valid && !cfg_clear;
   assign cmd_take = take;

   always_comb begin
      state_in = state_ff;
      wpos_in = wpos_ff;
      rpos_in = rpos_ff;
      cw_in = cw_ff;
      cr_in = cr_ff;
      pend_in = pend_ff;
      di_in = di_ff;
      ovf_in = ovf_ff;
      mv_addr_in = mv_addr_ff;
      cur_in = cur_ff;
      strobe_in = 1'b0;
      rsp_in = '0;
      p_we = 1'b0;
      c_we = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cur_in = cmd;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
            unique case (cur_ff.opcode)
               mpmq_pkg::OpPush: begin
                  strobe_in = 1'b1;
                  if (32'(prod_idx) < 32'(np) && nw != rpos_ff[pi]) begin
                     p_we = 1'b1;
                     wpos_in[pi] = nw;
                     pend_in[pi] = 1'b1;
                     rsp_in.ok = 1'b1;
                  end
               end
               mpmq_pkg::OpInspect: begin
                  if (cr_ff != cw_ff) begin
                     strobe_in = 1'b1;
                     rsp_in.ok = 1'b1;
                     rsp_in.begin_pos = cr_ff;
                     rsp_in.end_pos = cw_ff;
                  end else if (pend_ff == '0) begin
                     strobe_in = 1'b1;
                  end else begin
                     pend_in = '0;
                     di_in = '0;
                     ovf_in = 1'b0;
                     state_in = ST_DRAIN;
                  end
               end
               mpmq_pkg::OpRead: begin
                  // Read data from the registered consumer RAM is ready in ST_DONE.
                  state_in = ST_DONE;
               end
               default: begin
                  strobe_in = 1'b1;
                  if (9'(cur_ff.end_limit) < 9'(cs)) begin
                     cr_in = cur_ff.end_limit;
                     rsp_in.ok = 1'b1;
                  end
                  rsp_in.more_pending = (cr_in != cw_ff) || (pend_ff != '0);
               end
            endcase
         end
         ST_DRAIN: begin
            // Scan one producer ring; start a move when it holds an item.
            if (32'(di_ff) >= 32'(np)) begin
               state_in = ST_DONE;
            end else if (rpos_ff[di_ff] == wpos_ff[di_ff]) begin
               if (32'(di_ff) + 1 >= 32'(np)) state_in = ST_DONE;
               else di_in = di_ff + PW'(1);
            end else if (ncw == cr_ff) begin
               ovf_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               mv_addr_in = CA'(cw_ff);
               cw_in = ncw;
               rpos_in[di_ff] = (rpos_ff[di_ff] == rs_last) ? '0
                                                            : rpos_ff[di_ff] + RW'(1);
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            c_we = 1'b1;
            state_in = ST_DRAIN;
         end
         default: begin
            strobe_in = 1'b1;
            state_in = ST_IDLE;
            if (cur_ff.opcode == mpmq_pkg::OpRead) begin
               if (cur_ff.position != cur_ff.end_limit) begin
                  if (9'(cur_ff.position) < 9'(cs)) begin
                     rsp_in.ok = 1'b1;
                     rsp_in.read_item = 64'(cdata);
                     rsp_in.next_position = pos_next;
                  end else begin
                     rsp_in.next_position = cur_ff.position;
                  end
               end
            end else if (ovf_ff) begin
               rsp_in.overflow = 1'b1;
            end else if (cr_ff != cw_ff) begin
               rsp_in.ok = 1'b1;
               rsp_in.begin_pos = cr_ff;
               rsp_in.end_pos = cw_ff;
            end
         end
      endcase
      if (cfg_clear) begin
         for (int i = 0; i < MaxProducers; i++) begin
            wpos_in[i] = '0;
            rpos_in[i] = '0;
         end
         cw_in = '0;
         cr_in = '0;
         pend_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < MaxProducers; i++) begin
            wpos_ff[i] <= '0;
            rpos_ff[i] <= '0;
         end
         cw_ff <= '0;
         cr_ff <= '0;
         pend_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wpos_ff <= wpos_in;
         rpos_ff <= rpos_in;
         cw_ff <= cw_in;
         cr_ff <= cr_in;
         pend_ff <= pend_in;
         strobe_ff <= strobe_in;
      end
      di_ff <= di_in;
      ovf_ff <= ovf_in;
      mv_addr_ff <= mv_addr_in;
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp = rsp_ff;

   `MPMQ_ASSERT_IMP(a_cw_range, clock, reset, 1'b1, 9'(cw_ff) < 9'(ConsSlots),
      "consumer writer out of range")
   `MPMQ_ASSERT_IMP(a_move_from_drain, clock, reset, state_ff == ST_MOVE,
      $past(state_ff) == ST_DRAIN, "move without drain step")
   `MPMQ_ASSERT_NEXT(a_take_idle, clock, reset, take, state_ff == ST_READ,
      "command taken but not started")
endmodule

[hw/rtl/multi_producer_merge_queue_unit.sv]
// Top level of the multi-producer merge queue: configuration registers,
// front command queue and back execution engine. Depends on mpmq_pkg.
//
// Every command passes through ST_READ. Push, release and an inspect that
// drains nothing answer from ST_READ; a read answers from ST_DONE once the
// registered RAM read is back; an inspect that drains alternates ST_DRAIN,
// which scans the producer rings in index order, with ST_MOVE for each item
// moved, ends early when the consumer ring overflows, and answers from
// ST_DONE. rsp_strobe is registered from the answering state. The back end
// runs one command at a time and takes the next one in the cycle it goes
// idle; the two-entry front queue raises busy when full. A configuration
// write flushes that queue and clears every ring position. Results are shown
// for one cycle on rsp_strobe and cannot be held off.
module multi_producer_merge_queue_unit #(
   parameter int MaxProducers  = mpmq_pkg::MaxProducers,
   parameter int ProducerDepth = mpmq_pkg::ProducerDepth,
   parameter int DataWidth     = mpmq_pkg::DataWidth
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  mpmq_pkg::req_type                req_data,
   output logic                             rsp_strobe,
   output mpmq_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [mpmq_pkg::CfgIdxWidth-1:0] csr_index,
   input  logic [mpmq_pkg::CfgWidth-1:0]    csr_wdata
);
   logic [3:0] pc_ff;
   logic [4:0] ipp_ff;
   logic       cmd_valid, cmd_take;
   mpmq_pkg::req_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 4'd8;
         ipp_ff <= 5'd16;
      end else if (csr_we) begin
         unique case (csr_index)
            mpmq_pkg::RegProducerCount:    pc_ff <= csr_wdata[3:0];
            default:                       ipp_ff <= csr_wdata;
         endcase
      end
   end

   mpmq_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_in(req_data), .flush(csr_we), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_take(cmd_take));

   mpmq_back #(.MaxProducers(MaxProducers), .ProducerDepth(ProducerDepth),
      .DataWidth(DataWidth)) u_back (
      .clock(clock), .reset(reset), .cfg_clear(csr_we),
      .ring_count(pc_ff), .items_per_producer(ipp_ff),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
      .rsp_strobe(rsp_strobe), .rsp(rsp_data));
endmodule

[tb/sv/mpmq_scoreboard.sv]
// Checker for the merge queue: tracks configuration writes, predicts every
// response from an internal copy of the queue state and compares it with the
// observed one. Depends on mpmq_pkg.
module mpmq_scoreboard (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  mpmq_pkg::req_type                req_data,
   input  logic                             rsp_strobe,
   input  mpmq_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [mpmq_pkg::CfgIdxWidth-1:0] csr_index,
   input  logic [mpmq_pkg::CfgWidth-1:0]    csr_wdata,
   output int                               fail_count,
   output int                               outstanding,
   output logic [7:0]                       cons_read_pos,
   output logic [7:0]                       cons_write_pos,
   output logic [128:0]                     cons_filled
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxProducers  = mpmq_pkg::MaxProducers;
   localparam int ProducerDepth = mpmq_pkg::ProducerDepth;
   localparam int RingSlots = ProducerDepth + 1;
   localparam int ConsSlots = MaxProducers * ProducerDepth + 1;

   logic [63:0] prod_slot [MaxProducers][RingSlots];
   int          prod_wr [MaxProducers];
   int          prod_rd [MaxProducers];
   logic [63:0] cons_slot [ConsSlots];
   int          cons_wr;
   int          cons_rd;
   logic [7:0]  pending;
   logic [3:0]  cfg_producers;
   logic [4:0]  cfg_items;
   mpmq_pkg::rsp_type expected_rsp [$];

   assign cons_read_pos  = cons_rd[7:0];
   assign cons_write_pos = cons_wr[7:0];

   function automatic int wrap_inc(int v, int size);
      return (v + 1 >= size) ? 0 : v + 1;
   endfunction

   function automatic int active_producers();
      if (cfg_producers == 0) return 1;
      if (cfg_producers > MaxProducers) return MaxProducers;
      return int'(cfg_producers);
   endfunction

   function automatic int active_items();
      if (cfg_items == 0) return 1;
      if (cfg_items > ProducerDepth) return ProducerDepth;
      return int'(cfg_items);
   endfunction

   task automatic clear_rings();
      for (int i = 0; i < MaxProducers; i++) begin
         prod_wr[i] = 0;
         prod_rd[i] = 0;
      end
      cons_wr = 0;
      cons_rd = 0;
      pending = '0;
   endtask

   task automatic predict_queue(input mpmq_pkg::req_type r);
      mpmq_pkg::rsp_type res;
      int      np;
      int      rs;
      int      cs;
      int      w;
      int      nw;
      int      ncw;
      int      pos;
      int      lim;
      logic    have;
      logic    ovf;
      np  = active_producers();
      rs  = active_items() + 1;
      cs  = np * active_items() + 1;
      res = '0;
      pos = int'(r.position);
      lim = int'(r.end_limit);
      case (r.opcode)
         mpmq_pkg::OpPush: begin
            if (r.producer < np) begin
               w  = prod_wr[r.producer];
               nw = wrap_inc(w, rs);
               if (nw != prod_rd[r.producer]) begin
                  prod_slot[r.producer][w] = r.item;
                  prod_wr[r.producer] = nw;
                  pending[r.producer] = 1'b1;
                  res.ok = 1'b1;
               end
            end
         end
         mpmq_pkg::OpInspect: begin
            have = cons_rd != cons_wr;
            if (!have && pending != 0) begin
               pending = '0;
               ovf = 1'b0;
               // Rings are merged in index order; a full consumer ring stops the merge.
               for (int i = 0; i < np && !ovf; i++) begin
                  while (prod_rd[i] != prod_wr[i]) begin
                     ncw = wrap_inc(cons_wr, cs);
                     if (ncw == cons_rd) begin
                        ovf = 1'b1;
                        break;
                     end
                     cons_slot[cons_wr] = prod_slot[i][prod_rd[i]];
                     cons_filled[cons_wr] = 1'b1;
                     cons_wr = ncw;
                     prod_rd[i] = wrap_inc(prod_rd[i], rs);
                  end
               end
               if (ovf) res.overflow = 1'b1;
               else have = cons_rd != cons_wr;
            end else if (!have) begin
               pending = '0;
            end
            if (have) begin
               res.ok        = 1'b1;
               res.begin_pos = cons_rd[7:0];
               res.end_pos   = cons_wr[7:0];
            end
         end
         mpmq_pkg::OpRead: begin
            if (pos != lim && pos < cs) begin
               res.ok            = 1'b1;
               res.read_item     = cons_slot[pos];
               res.next_position = 8'(wrap_inc(pos, cs));
            end else if (pos != lim) begin
               res.next_position = pos[7:0];
            end
         end
         default: begin
            if (lim < cs) begin
               cons_rd = lim;
               res.ok  = 1'b1;
            end
            res.more_pending = (cons_rd != cons_wr) || (pending != 0);
         end
      endcase
      expected_rsp.push_back(res);
   endtask

   task automatic compare_rsp(input mpmq_pkg::rsp_type got);
      mpmq_pkg::rsp_type want;
      if (expected_rsp.size() == 0) begin
         $error("response strobe with no transfer outstanding");
         fail_count++;
         return;
      end
      want = expected_rsp.pop_front();
      if (got.ok !== want.ok) begin
         $error("ok: expected %0h, got %0h", want.ok, got.ok);
         fail_count++;
      end
      if (got.begin_pos !== want.begin_pos) begin
         $error("begin_pos: expected %0h, got %0h", want.begin_pos, got.begin_pos);
         fail_count++;
      end
      if (got.end_pos !== want.end_pos) begin
         $error("end_pos: expected %0h, got %0h", want.end_pos, got.end_pos);
         fail_count++;
      end
      if (got.read_item !== want.read_item) begin
         $error("read_item: expected %0h, got %0h", want.read_item, got.read_item);
         fail_count++;
      end
      if (got.next_position !== want.next_position) begin
         $error("next_position: expected %0h, got %0h", want.next_position,
                got.next_position);
         fail_count++;
      end
      if (got.more_pending !== want.more_pending) begin
         $error("more_pending: expected %0h, got %0h", want.more_pending,
                got.more_pending);
         fail_count++;
      end
      if (got.overflow !== want.overflow) begin
         $error("overflow: expected %0h, got %0h", want.overflow, got.overflow);
         fail_count++;
      end
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
      cons_filled = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cfg_producers = 4'd8;
         cfg_items     = 5'd16;
         cons_filled   = '0;
         clear_rings();
         expected_rsp.delete();
      end else begin
         // Responses belong to earlier transfers, so they are matched first.
         if (rsp_strobe) compare_rsp(rsp_data);
         if (csr_we) begin
            if (csr_index == mpmq_pkg::RegProducerCount) cfg_producers = csr_wdata[3:0];
            else cfg_items = csr_wdata;
            clear_rings();
         end
         if (start && !busy) predict_queue(req_data);
      end
      outstanding = expected_rsp.size();
   end
endmodule

[tb/sv/multi_producer_merge_queue_unit_test.sv]
// Top of the merge queue testbench: clock, reset, stimulus and verdict.
// Depends on mpmq_pkg, mpmq_scoreboard and multi_producer_merge_queue_unit.
module multi_producer_merge_queue_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 20000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   mpmq_pkg::req_type                req_data = '0;
   logic                             rsp_strobe;
   mpmq_pkg::rsp_type                rsp_data;
   logic                             csr_we = 1'b0;
   logic [mpmq_pkg::CfgIdxWidth-1:0] csr_index = '0;
   logic [mpmq_pkg::CfgWidth-1:0]    csr_wdata = '0;
   int                               fail_count;
   int                               outstanding;
   logic [7:0]                       cons_read_pos;
   logic [7:0]                       cons_write_pos;
   logic [128:0]                     cons_filled;
   int                               idle_pct = 0;
   int                               num_producers = 8;
   int                               num_items = 16;
   int                               stall_cycles = 0;

   always #2 clock = ~clock;

   multi_producer_merge_queue_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   mpmq_scoreboard u_scoreboard (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .outstanding(outstanding), .cons_read_pos(cons_read_pos),
      .cons_write_pos(cons_write_pos), .cons_filled(cons_filled)
   );

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || reset) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int cons_size();
      int np;
      int ni;
      np = (num_producers == 0) ? 1
         : (num_producers > mpmq_pkg::MaxProducers) ? mpmq_pkg::MaxProducers
                                                    : num_producers;
      ni = (num_items == 0) ? 1
         : (num_items > mpmq_pkg::ProducerDepth) ? mpmq_pkg::ProducerDepth : num_items;
      return np * ni + 1;
   endfunction

   task automatic send(input mpmq_pkg::req_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(6)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mpmq_pkg::CfgIdxWidth-1:0] idx,
                            input int value);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[mpmq_pkg::CfgWidth-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == mpmq_pkg::RegProducerCount) num_producers = value & 15;
      else num_items = value & 31;
   endtask

   function automatic mpmq_pkg::req_type op(input logic [1:0] code, input int prod,
                                            input logic [63:0] val, input int pos,
                                            input int lim);
      mpmq_pkg::req_type r;
      r.opcode    = code;
      r.producer  = prod[5:0];
      r.item      = val;
      r.position  = pos[7:0];
      r.end_limit = lim[7:0];
      // A read must never land on a consumer slot that has not been filled yet.
      if (code == mpmq_pkg::OpRead && r.position != r.end_limit
          && r.position < cons_size() && !cons_filled[r.position])
         r.end_limit = r.position;
      return r;
   endfunction

   function automatic mpmq_pkg::req_type random_op();
      int          sel;
      int          cs;
      int          span;
      int          pos;
      logic [63:0] val;
      sel = $urandom_range(99);
      cs  = cons_size();
      val = {$urandom, $urandom};
      if ($urandom_range(9) == 0) val = ($urandom_range(1) == 0) ? '0 : '1;
      if (sel < 50) begin
         if ($urandom_range(9) == 0)
            return op(mpmq_pkg::OpPush, $urandom_range(63), val, 0, 0);
         return op(mpmq_pkg::OpPush, $urandom_range(cs > 1 ? num_producers : 0), val,
                   $urandom_range(255), $urandom_range(255));
      end
      if (sel < 65) return op(mpmq_pkg::OpInspect, $urandom_range(63), val,
                              $urandom_range(255), $urandom_range(255));
      if (sel < 90) begin
         span = (int'(cons_write_pos) + cs - int'(cons_read_pos)) % cs;
         if (span != 0 && $urandom_range(9) < 8) begin
            pos = (int'(cons_read_pos) + $urandom_range(span - 1)) % cs;
            return op(mpmq_pkg::OpRead, $urandom_range(63), val, pos,
                      int'(cons_write_pos));
         end
         return op(mpmq_pkg::OpRead, $urandom_range(63), val, $urandom_range(255),
                   $urandom_range(255));
      end
      if ($urandom_range(9) < 7) return op(mpmq_pkg::OpRelease, $urandom_range(63), val,
                                           $urandom_range(255), int'(cons_write_pos));
      return op(mpmq_pkg::OpRelease, $urandom_range(63), val, $urandom_range(255),
                $urandom_range(255));
   endfunction

   initial begin
      int pc_list [6];
      int ip_list [6];
      pc_list = '{8, 1, 15, 0, 3, 8};
      ip_list = '{16, 1, 31, 0, 5, 16};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty inspect, extremes of the item, bad producers, reads and releases.
      send(op(mpmq_pkg::OpInspect, 0, '0, 0, 0));
      send(op(mpmq_pkg::OpPush, 0, '0, 0, 0));
      send(op(mpmq_pkg::OpPush, 7, '1, 255, 255));
      send(op(mpmq_pkg::OpPush, 8, 64'h5a5a, 0, 0));
      send(op(mpmq_pkg::OpPush, 63, 64'h1234, 0, 0));
      send(op(mpmq_pkg::OpRelease, 0, '0, 0, 0));
      send(op(mpmq_pkg::OpInspect, 0, '0, 0, 0));
      send(op(mpmq_pkg::OpRead, 0, '0, 0, 2));
      send(op(mpmq_pkg::OpRead, 0, '0, 1, 2));
      send(op(mpmq_pkg::OpRead, 0, '0, 2, 2));
      send(op(mpmq_pkg::OpRead, 0, '0, 200, 2));
      send(op(mpmq_pkg::OpRelease, 0, '0, 0, 200));
      send(op(mpmq_pkg::OpRelease, 0, '0, 0, 2));
      send(op(mpmq_pkg::OpInspect, 0, '0, 0, 0));
      write_reg(mpmq_pkg::RegProducerCount, 1);
      write_reg(mpmq_pkg::RegItemsPerProducer, 1);
      send(op(mpmq_pkg::OpPush, 0, 64'hdead_beef, 0, 0));
      send(op(mpmq_pkg::OpPush, 0, 64'hfeed, 0, 0));
      send(op(mpmq_pkg::OpPush, 1, 64'hfeed, 0, 0));
      send(op(mpmq_pkg::OpInspect, 0, '0, 0, 0));
      send(op(mpmq_pkg::OpRead, 0, '0, 0, 1));
      send(op(mpmq_pkg::OpRead, 0, '0, 1, 0));
      send(op(mpmq_pkg::OpRelease, 0, '0, 0, 1));
      send(op(mpmq_pkg::OpInspect, 0, '0, 0, 0));

      for (int phase = 0; phase < 6; phase++) begin
         write_reg(mpmq_pkg::RegProducerCount, pc_list[phase]);
         write_reg(mpmq_pkg::RegItemsPerProducer, ip_list[phase]);
         idle_pct = (phase % 3 == 0) ? 27 : (phase % 3 == 1) ? 67 : 0;
         repeat (210) send(random_op());
      end

      wait_idle();
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
